// File: rtl/core/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants
// Widths, codes and pipeline structs for the ADSR envelope amplifier.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int TIME_BITS = 24;        // width of the time inputs
  localparam int RATE      = 44100;     // samples per 128 register steps
  localparam int LVL_W     = 7;         // register width
  localparam int SMP_W     = 16;        // Q1.15 sample
  localparam int GAIN_W    = 16;        // Q0.16 gain
  localparam int QUO_W     = GAIN_W;    // divider quotient bits
  localparam int PH_W      = 3;
  localparam int CFG_IDX_W = 3;

  // Longest phase length RATE*127 fits here
  localparam int DEN_W = $clog2(RATE * ((1 << LVL_W) - 1) + 1);
  localparam int T128_W = TIME_BITS + LVL_W;

  localparam int DIV_STEPS     = 8;
  localparam int BITS_PER_STEP = QUO_W / DIV_STEPS;

  localparam int IN_FLD_W  = 2 * TIME_BITS + SMP_W;
  localparam int IN_W      = ((IN_FLD_W + 7) / 8) * 8;
  localparam int OUT_FLD_W = SMP_W + GAIN_W + PH_W;
  localparam int OUT_W     = ((OUT_FLD_W + 7) / 8) * 8;

  typedef enum logic [PH_W-1:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_IDLE    = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_RELEASE = 3'd2,
    REG_PEAK    = 3'd3,
    REG_HOLD    = 3'd4
  } cfg_idx_t;

  // Restoring divider state: remainder, numerator bits still to shift in,
  // quotient so far, divisor
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] lo;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } div_t;

  // Per-item payload riding alongside the divider
  typedef struct packed {
    phase_t           phase;
    logic             neg;    // decay ramps up (peak below hold)
    logic [SMP_W-1:0] smp;
  } side_t;

  // Phase length in samples times 128
  function automatic logic [DEN_W-1:0] phase_len(input logic [LVL_W-1:0] steps);
    phase_len = DEN_W'(RATE * int'(steps));
  endfunction

endpackage

// File: rtl/core/adsr_envelope_amplifier.sv
// ----------------------------------------------------------------------------
// adsr_envelope_amplifier: linear ADSR gain and sample scaling
// Finds the envelope phase, divides out a linear gain and scales the sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one transfer per voice sample carrying the time
//   since note-on, the time since release (0 while held) and a Q1.15 sample.
//   Output stream m_axis_*: one transfer per input transfer, in order, with
//   the scaled sample, the Q0.16 gain and the phase code.
//   Config port: cfg_we/cfg_index/cfg_data write one 7-bit register per
//   cycle; write only while no transfer is in flight.
// Timing:
//   14-stage pipeline, one transfer per cycle sustained while m_axis_tready stays high.
//   The gain division is a restoring divider spread over 8 stages of 2
//   quotient bits each; it sets the depth.
// Reset:
//   rst empties the pipeline and loads attack/decay/release = 0 and
//   peak/hold = 127.
// Stall:
//   Each stage holds when it is full and the stage after it holds, so
//   bubbles close up and s_axis_tready drops only when all stages are full.
// ----------------------------------------------------------------------------
module adsr_envelope_amplifier (
  input  logic                            clk,
  input  logic                            rst,
  // time_on, time_released, sample_in (lowest bits first)
  input  logic [adsr_pkg::IN_W-1:0]       s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sample_out, gain, phase (lowest bits first)
  output logic [adsr_pkg::OUT_W-1:0]      m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adsr_pkg::LVL_W-1:0]      cfg_data
);
  import adsr_pkg::*;

  localparam int ST_IN   = 1;
  localparam int ST_PH   = 2;
  localparam int ST_MUL  = 3;
  localparam int ST_DIV0 = 4;                    // first divider stage
  localparam int ST_GAIN = ST_DIV0 + DIV_STEPS;
  localparam int ST_PROD = ST_GAIN + 1;
  localparam int NST     = ST_PROD + 1;          // output register
  localparam int PROD_W  = LVL_W + DEN_W;
  localparam int SHL_W   = QUO_W - LVL_W;        // numerator is 512 * product

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LVL_W-1:0] attack_steps, decay_time, release_time, peak_level, hold_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_steps <= '0;
      decay_time   <= '0;
      release_time <= '0;
      peak_level   <= '1;
      hold_level   <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_ATTACK:  attack_steps <= cfg_data;
        REG_DECAY:   decay_time   <= cfg_data;
        REG_RELEASE: release_time <= cfg_data;
        REG_PEAK:    peak_level   <= cfg_data;
        REG_HOLD:    hold_level   <= cfg_data;
        default: ;                               // unmapped index, dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when its successor
  // loads. Valid bits travel with the data.
  // --------------------------------------------------------------------------
  logic [NST:1]   vld;
  logic [NST+1:1] ld;
  logic [NST:1]   vld_prev;

  always_comb begin
    ld[NST+1] = m_axis_tready;
    for (int k = NST; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign vld_prev = {vld[NST-1:1], s_axis_tvalid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (ld[k]) begin
          vld[k] <= vld_prev[k];
        end
      end
    end
  end

  assign s_axis_tready = ld[ST_IN];
  assign m_axis_tvalid = vld[NST];

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0] t1, s1;
  logic [SMP_W-1:0]     smp1;

  always_ff @(posedge clk) begin
    if (ld[ST_IN]) begin
      t1   <= s_axis_tdata[TIME_BITS-1:0];
      s1   <= s_axis_tdata[2*TIME_BITS-1:TIME_BITS];
      smp1 <= s_axis_tdata[IN_FLD_W-1:2*TIME_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: phase select. Every dividing phase reduces to
  //   gain = 512 * mult * x / den  with x < den,
  // attack: x = 128t, decay: x = 128t - a_len, release: x = r_len - 128s.
  // --------------------------------------------------------------------------
  logic [DEN_W-1:0]  a_len, d_len, r_len;
  logic [DEN_W:0]    ad_len;
  logic [T128_W-1:0] t128, s128;
  logic [T128_W-1:0] x_full;
  logic [DEN_W-1:0]  x_nxt, den_nxt;
  logic [LVL_W-1:0]  mult_nxt;
  side_t             side_nxt;

  assign a_len  = phase_len(attack_steps);
  assign d_len  = phase_len(decay_time);
  assign r_len  = phase_len(release_time);
  assign ad_len = {1'b0, a_len} + {1'b0, d_len};
  assign t128   = {t1, LVL_W'(0)};
  assign s128   = {s1, LVL_W'(0)};

  always_comb begin
    side_nxt.smp = smp1;
    side_nxt.neg = peak_level < hold_level;
    x_full       = '0;
    den_nxt      = '0;
    mult_nxt     = '0;
    if (t128 < T128_W'(a_len)) begin
      side_nxt.phase = PH_ATTACK;
      x_full         = t128;
      den_nxt        = a_len;
      mult_nxt       = peak_level;
    end else if (t128 < T128_W'(ad_len)) begin
      side_nxt.phase = PH_DECAY;
      x_full         = t128 - T128_W'(a_len);
      den_nxt        = d_len;
      mult_nxt       = side_nxt.neg ? hold_level - peak_level : peak_level - hold_level;
    end else if (s1 == '0) begin
      side_nxt.phase = PH_SUSTAIN;
    end else if (s128 < T128_W'(r_len)) begin
      side_nxt.phase = PH_RELEASE;
      x_full         = T128_W'(r_len) - s128;
      den_nxt        = r_len;
      mult_nxt       = hold_level;
    end else begin
      side_nxt.phase = PH_IDLE;
    end
  end

  assign x_nxt = x_full[DEN_W-1:0];   // x < den in every dividing phase

  logic [DEN_W-1:0] x2, den2;
  logic [LVL_W-1:0] mult2;
  side_t            side2;

  always_ff @(posedge clk) begin
    if (ld[ST_PH]) begin
      x2    <= x_nxt;
      den2  <= den_nxt;
      mult2 <= mult_nxt;
      side2 <= side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: product mult*x, then load the divider. Numerator is
  // product << 9, so its top part (product >> 7) is already below den.
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] prod_mx;
  div_t              dv [0:DIV_STEPS];
  side_t             sd [0:DIV_STEPS];

  assign prod_mx = PROD_W'(mult2) * PROD_W'(x2);

  always_ff @(posedge clk) begin
    if (ld[ST_MUL]) begin
      dv[0].rem <= prod_mx[PROD_W-1:LVL_W];
      dv[0].lo  <= {prod_mx[LVL_W-1:0], SHL_W'(0)};
      dv[0].quo <= '0;
      dv[0].den <= den2;
      sd[0]     <= side2;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4..11: pipelined restoring divider
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    adsr_div_step u_step (
      .clk  (clk),
      .ld   (ld[ST_DIV0 + g]),
      .din  (dv[g]),
      .sin  (sd[g]),
      .dout (dv[g+1]),
      .sout (sd[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 12: gain per phase. Decay moves from 512*peak toward 512*hold.
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] quo, peak512, hold512, gain_nxt;
  side_t             side_q;

  assign quo     = dv[DIV_STEPS].quo;
  assign side_q  = sd[DIV_STEPS];
  assign peak512 = {peak_level, SHL_W'(0)};
  assign hold512 = {hold_level, SHL_W'(0)};

  always_comb begin
    case (side_q.phase)
      PH_ATTACK:  gain_nxt = quo;
      PH_DECAY:   gain_nxt = side_q.neg ? peak512 + quo : peak512 - quo;
      PH_SUSTAIN: gain_nxt = hold512;
      PH_RELEASE: gain_nxt = quo;
      default:    gain_nxt = '0;
    endcase
  end

  logic [GAIN_W-1:0] gain12;
  logic [SMP_W-1:0]  smp12;
  phase_t            phase12;

  always_ff @(posedge clk) begin
    if (ld[ST_GAIN]) begin
      gain12  <= gain_nxt;
      smp12   <= side_q.smp;
      phase12 <= side_q.phase;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 13: signed sample times unsigned gain
  // --------------------------------------------------------------------------
  logic signed [SMP_W+GAIN_W:0] prod13;
  logic [GAIN_W-1:0]            gain13;
  phase_t                       phase13;

  always_ff @(posedge clk) begin
    if (ld[ST_PROD]) begin
      prod13  <= $signed(smp12) * $signed({1'b0, gain12});
      gain13  <= gain12;
      phase13 <= phase12;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 14: output register; >>16 with floor is the upper product bits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld[NST]) begin
      m_axis_tdata <= {(OUT_W - OUT_FLD_W)'(0), phase13, gain13,
                       prod13[SMP_W+GAIN_W-1:GAIN_W]};
    end
  end

endmodule

// File: rtl/core/adsr_div_step.sv
// ----------------------------------------------------------------------------
// adsr_div_step: one registered divider stage
// Retires BITS_PER_STEP quotient bits by restoring compare and subtract.
// ----------------------------------------------------------------------------
module adsr_div_step (
  input  logic          clk,
  input  logic          ld,
  input  adsr_pkg::div_t  din,
  input  adsr_pkg::side_t sin,
  output adsr_pkg::div_t  dout,
  output adsr_pkg::side_t sout
);
  import adsr_pkg::*;

  div_t nxt;

  always_comb begin
    logic [DEN_W:0] r;
    nxt = din;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r = {nxt.rem, nxt.lo[QUO_W-1]};
      nxt.lo = nxt.lo << 1;
      if (r >= {1'b0, nxt.den}) begin
        r = r - {1'b0, nxt.den};
        nxt.quo = {nxt.quo[QUO_W-2:0], 1'b1};
      end else begin
        nxt.quo = {nxt.quo[QUO_W-2:0], 1'b0};
      end
      nxt.rem = r[DEN_W-1:0];   // remainder stays below the divisor
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dout <= nxt;
      sout <= sin;
    end
  end

endmodule
